// ===== src/tsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_pkg
// Types and constants shared by the spiral tile walker modules.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int TILE_SIZE    = 256;
  localparam int ZOOM_LEVELS  = 21;
  localparam int RADIUS_SHIFT = 17;

  localparam int COORD_W  = 20;
  localparam int POS_W    = COORD_W + 1;
  localparam int GRID_W   = POS_W + 1;
  localparam int ZOOM_W   = 5;
  localparam int SCALE_W  = 20;
  localparam int RADIUS_W = 16;
  localparam int RING_W   = 20;
  localparam int COV_W    = RING_W + 1 + SCALE_W;
  localparam int TILE_W   = $clog2(TILE_SIZE + 1);
  localparam int CMP_W    = COV_W + TILE_W;

  localparam logic [ZOOM_W-1:0] ZOOM_MAX = ZOOM_W'(ZOOM_LEVELS - 1);
  localparam logic [ZOOM_W-1:0] ZOOM_MIN_WALK = ZOOM_W'(2);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    LEG_UP    = 2'd0,
    LEG_LEFT  = 2'd1,
    LEG_DOWN  = 2'd2,
    LEG_RIGHT = 2'd3
  } leg_e;

  typedef struct packed {
    logic                func;
    logic [COORD_W-1:0]  center_col;
    logic [COORD_W-1:0]  center_row;
    logic [ZOOM_W-1:0]   zoom;
    logic [SCALE_W-1:0]  scale;
    logic [RADIUS_W-1:0] coverage_radius;
  } tsw_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [ZOOM_W-1:0]  tile_zoom;
    logic               found;
  } tsw_res_t;

endpackage
`default_nettype wire

// ===== src/tsw_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_in_reg
// Request register in front of the walker step logic.
// ----------------------------------------------------------------------------
module tsw_in_reg
  import tsw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire tsw_req_t req_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output tsw_req_t      req_o
);

  logic     valid_q;
  tsw_req_t req_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tsw_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_walker
// Walk state and single-step spiral logic; state advances on each request.
// ----------------------------------------------------------------------------
module tsw_walker
  import tsw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire tsw_req_t req_i,
  output tsw_res_t      res_o
);

  logic [POS_W-1:0]    cur_x_q, cur_x_d;
  logic [POS_W-1:0]    cur_y_q, cur_y_d;
  logic [ZOOM_W-1:0]   zoom_q, zoom_d;
  logic [RING_W-1:0]   ring_q, ring_d;
  leg_e                leg_q, leg_d;
  logic [POS_W-1:0]    steps_q, steps_d;
  logic                ended_q, ended_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [COV_W-1:0]    cov_q, cov_d;

  logic [GRID_W-1:0]   grid;
  logic [ZOOM_W-1:0]   start_zoom;
  logic [POS_W-1:0]    x1, y1, x2, y2;
  logic [POS_W-1:0]    steps_n;
  logic                stop;
  logic                leg_full;
  logic [CMP_W-1:0]    lhs, rhs;

  assign grid = GRID_W'(1) << zoom_q;
  assign lhs  = CMP_W'(cov_q) * CMP_W'(TILE_SIZE);
  assign rhs  = CMP_W'(radius_q) << RADIUS_SHIFT;
  assign start_zoom = (req_i.zoom > ZOOM_MAX) ? ZOOM_MAX : req_i.zoom;
  assign steps_n  = steps_q + POS_W'(1);
  assign leg_full = steps_n >= {ring_q, 1'b0};

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    zoom_d   = zoom_q;
    ring_d   = ring_q;
    leg_d    = leg_q;
    steps_d  = steps_q;
    ended_d  = ended_q;
    radius_d = radius_q;
    scale_d  = scale_q;
    cov_d    = cov_q;
    res_o    = '0;
    stop     = 1'b0;
    x1       = cur_x_q;
    y1       = cur_y_q;
    x2       = cur_x_q;
    y2       = cur_y_q;

    // ring start: step down-right first
    if (leg_q == LEG_UP && steps_q == '0) begin
      if ((GRID_W'(cur_x_q) + GRID_W'(1) >= grid) ||
          (GRID_W'(cur_y_q) + GRID_W'(1) >= grid)) begin
        stop = 1'b1;
      end
      x1 = cur_x_q + POS_W'(1);
      y1 = cur_y_q + POS_W'(1);
    end

    unique case (leg_q)
      LEG_UP: begin
        if (y1 <= POS_W'(1)) stop = 1'b1;
        x2 = x1;
        y2 = y1 - POS_W'(1);
      end
      LEG_LEFT: begin
        if (x1 <= POS_W'(1)) stop = 1'b1;
        x2 = x1 - POS_W'(1);
        y2 = y1;
      end
      LEG_DOWN: begin
        if (GRID_W'(y1) + GRID_W'(1) >= grid) stop = 1'b1;
        x2 = x1;
        y2 = y1 + POS_W'(1);
      end
      LEG_RIGHT: begin
        if (GRID_W'(x1) + GRID_W'(1) >= grid) stop = 1'b1;
        x2 = x1 + POS_W'(1);
        y2 = y1;
      end
    endcase

    if (req_i.func == FUNC_START) begin
      cur_x_d  = POS_W'(req_i.center_col);
      cur_y_d  = POS_W'(req_i.center_row);
      zoom_d   = start_zoom;
      scale_d  = req_i.scale;
      radius_d = req_i.coverage_radius;
      ring_d   = RING_W'(1);
      leg_d    = LEG_UP;
      steps_d  = '0;
      ended_d  = start_zoom < ZOOM_MIN_WALK;
      // (2*ring+1)*scale for ring one
      cov_d    = COV_W'(req_i.scale) + COV_W'({req_i.scale, 1'b0});
      res_o.tile_x    = req_i.center_col;
      res_o.tile_y    = req_i.center_row;
      res_o.tile_zoom = start_zoom;
      res_o.found     = 1'b1;
    end else if (!ended_q) begin
      if (stop) begin
        ended_d = 1'b1;
      end else begin
        cur_x_d = x2;
        cur_y_d = y2;
        steps_d = leg_full ? '0 : steps_n;
        if (leg_full) begin
          if (leg_q == LEG_RIGHT) begin
            if (lhs > rhs) ended_d = 1'b1;
            if (&ring_q) ended_d = 1'b1;
            ring_d = ring_q + RING_W'(1);
            cov_d  = cov_q + COV_W'({scale_q, 1'b0});
            leg_d  = LEG_UP;
          end else begin
            leg_d = leg_e'(leg_q + 2'd1);
          end
        end
        res_o.tile_x    = x2[COORD_W-1:0];
        res_o.tile_y    = y2[COORD_W-1:0];
        res_o.tile_zoom = zoom_q;
        res_o.found     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      zoom_q   <= '0;
      ring_q   <= '0;
      leg_q    <= LEG_UP;
      steps_q  <= '0;
      ended_q  <= 1'b1;
      radius_q <= '0;
      scale_q  <= '0;
      cov_q    <= '0;
    end else if (fire_i) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      zoom_q   <= zoom_d;
      ring_q   <= ring_d;
      leg_q    <= leg_d;
      steps_q  <= steps_d;
      ended_q  <= ended_d;
      radius_q <= radius_d;
      scale_q  <= scale_d;
      cov_q    <= cov_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/tsw_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_out_reg
// Result register; holds a tile until the consumer takes it.
// ----------------------------------------------------------------------------
module tsw_out_reg
  import tsw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire tsw_res_t res_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output tsw_res_t      res_o
);

  logic     valid_q;
  tsw_res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tile_spiral_coverage_walker.sv =====
// an accepted request is registered in the input stage, and its result in the output stage
// throughput: one request per cycle while results are taken, limited by the single-step walk state
// the coverage product is kept as a running sum, so no multiplier sits in the loop
// reset: both stages empty, no walk active, next requests answer not found
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_spiral_coverage_walker
// Square spiral tile generator: start request returns the center tile, each
// next request returns one more tile of the spiral around it, or not found once the walk has ended.
// ----------------------------------------------------------------------------
module tile_spiral_coverage_walker
  import tsw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire tsw_req_t req_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output tsw_res_t      res_o
);

  logic     in_valid;
  logic     out_ready;
  logic     fire;
  tsw_req_t in_req;
  tsw_res_t step_res;

  assign fire = in_valid && out_ready;

  tsw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_i),
    .ready_o (req_ready_o),
    .req_i   (req_i),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .req_o   (in_req)
  );

  tsw_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req),
    .res_o  (step_res)
  );

  tsw_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .res_i   (step_res),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .res_o   (res_o)
  );

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid |-> req_ready_o)
    else $error("input stage empty but request not taken");

  a_start_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_req.func == FUNC_START |=> res_valid_o && res_o.found)
    else $error("start request did not return the center tile");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.found |->
      res_o.tile_x == '0 && res_o.tile_y == '0 && res_o.tile_zoom == '0)
    else $error("end of walk with nonzero tile fields");

  a_zoom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> res_o.tile_zoom <= ZOOM_MAX)
    else $error("tile zoom above top level");

endmodule
`default_nettype wire

// ===== bench/tile_spiral_coverage_walker_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_spiral_coverage_walker_tb
// Drives start and next requests into the spiral tile walker and compares
// every returned tile against a cycle-free predictor of the spiral walk:
// ring starts, the four legs, grid edges, coverage end and zoom saturation.
// Both handshake sides idle in random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module tile_spiral_coverage_walker_tb;
  import tsw_pkg::*;

  localparam int TOTAL_REQUESTS = 824;
  localparam int CALM_REQUESTS  = 100;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int DRAIN_CYCLES   = 20;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     req_valid   = 1'b0;
  tsw_req_t req         = '0;
  logic     res_ready   = 1'b0;
  logic     req_ready_o;
  logic     res_valid_o;
  tsw_res_t res_o;

  tile_spiral_coverage_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready_o),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predicted walk state
  logic [POS_W-1:0]    walk_x;
  logic [POS_W-1:0]    walk_y;
  logic [ZOOM_W-1:0]   walk_zoom;
  logic [RING_W-1:0]   ring_no;
  leg_e                leg_q;
  logic [POS_W-1:0]    leg_count;
  logic                walk_done;
  logic [SCALE_W-1:0]  walk_scale;
  logic [RADIUS_W-1:0] walk_radius;

  tsw_res_t expected_tiles[$];
  tsw_res_t want_tile;
  int       errors        = 0;
  int       requests_sent = 0;
  int       cycle_cnt     = 0;
  int       stall_left    = 0;
  bit       idle_en       = 1'b1;

  function automatic tsw_res_t stop_walk();
    walk_done = 1'b1;
    return '0;
  endfunction

  function automatic tsw_res_t next_spiral_tile(tsw_req_t r);
    logic [GRID_W-1:0]  grid;
    logic [ZOOM_W-1:0]  z;
    longint unsigned    cover_lhs;
    longint unsigned    cover_rhs;
    if (r.func == FUNC_START) begin
      z = (r.zoom > ZOOM_MAX) ? ZOOM_MAX : r.zoom;
      walk_x      = {1'b0, r.center_col};
      walk_y      = {1'b0, r.center_row};
      walk_zoom   = z;
      walk_scale  = r.scale;
      walk_radius = r.coverage_radius;
      ring_no     = RING_W'(1);
      leg_q       = LEG_UP;
      leg_count   = '0;
      walk_done   = (z < ZOOM_MIN_WALK);
      return {r.center_col, r.center_row, z, 1'b1};
    end
    if (walk_done) return '0;
    grid = GRID_W'(1) << walk_zoom;
    if (leg_q == LEG_UP && leg_count == 0) begin
      if (walk_x + 1 >= grid || walk_y + 1 >= grid) return stop_walk();
      walk_x = walk_x + 1'b1;
      walk_y = walk_y + 1'b1;
    end
    case (leg_q)
      LEG_UP: begin
        if (walk_y <= 1) return stop_walk();
        walk_y = walk_y - 1'b1;
      end
      LEG_LEFT: begin
        if (walk_x <= 1) return stop_walk();
        walk_x = walk_x - 1'b1;
      end
      LEG_DOWN: begin
        if (walk_y + 1 >= grid) return stop_walk();
        walk_y = walk_y + 1'b1;
      end
      default: begin
        if (walk_x + 1 >= grid) return stop_walk();
        walk_x = walk_x + 1'b1;
      end
    endcase
    leg_count = leg_count + 1'b1;
    if (leg_count >= {ring_no, 1'b0}) begin
      leg_count = '0;
      if (leg_q == LEG_RIGHT) begin
        cover_lhs = (2 * longint'(ring_no) + 1) * TILE_SIZE * longint'(walk_scale);
        cover_rhs = longint'(walk_radius) << RADIUS_SHIFT;
        if (cover_lhs > cover_rhs) walk_done = 1'b1;
        ring_no = ring_no + 1'b1;
        if (ring_no == 0) walk_done = 1'b1;
        leg_q = LEG_UP;
      end else begin
        leg_q = leg_e'(leg_q + 2'd1);
      end
    end
    return {walk_x[COORD_W-1:0], walk_y[COORD_W-1:0], walk_zoom, 1'b1};
  endfunction

  function automatic tsw_req_t random_req(logic func);
    tsw_req_t r;
    r.func            = func;
    r.center_col      = COORD_W'($urandom);
    r.center_row      = COORD_W'($urandom);
    r.zoom            = ZOOM_W'($urandom);
    r.scale           = SCALE_W'($urandom);
    r.coverage_radius = RADIUS_W'($urandom);
    return r;
  endfunction

  function automatic tsw_req_t start_req(int x, int y, int z, int s, int radius);
    tsw_req_t r;
    r                 = random_req(FUNC_START);
    r.center_col      = COORD_W'(x);
    r.center_row      = COORD_W'(y);
    r.zoom            = ZOOM_W'(z);
    r.scale           = SCALE_W'(s);
    r.coverage_radius = RADIUS_W'(radius);
    return r;
  endfunction

  task automatic issue_request(input tsw_req_t r);
    if (requests_sent >= TOTAL_REQUESTS - CALM_REQUESTS) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    expected_tiles.insert(expected_tiles.size(), next_spiral_tile(r));
    requests_sent++;
  endtask

  task automatic issue_nexts(input int count);
    repeat (count) issue_request(random_req(FUNC_NEXT));
  endtask

  task automatic test_next_without_walk();
    issue_nexts(1);
  endtask

  task automatic test_low_zoom();
    issue_request(start_req(0, 0, 0, 0, 0));
    issue_nexts(1);
    issue_request(start_req(1, 1, 1, 'h10000, 50));
    issue_nexts(1);
  endtask

  task automatic test_field_extremes();
    issue_request(start_req('hFFFFF, 'hFFFFF, 'h1F, 'hFFFFF, 'hFFFF));
    issue_nexts(1);
  endtask

  task automatic test_full_ring_coverage();
    issue_request(start_req(3, 3, 3, 'h10000, 100));
    issue_nexts(9);
  endtask

  task automatic test_left_edge_zero_scale();
    issue_request(start_req(1, 5, 4, 0, 0));
    issue_nexts(4);
  endtask

  task automatic test_center_outside_grid();
    issue_request(start_req(9, 0, 2, 'h10000, 1000));
    issue_nexts(1);
  endtask

  task automatic test_random_walks();
    int       z;
    int       s;
    int       radius;
    int       nexts;
    tsw_req_t r;
    while (requests_sent < TOTAL_REQUESTS) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any field pattern, start or next
        r = random_req(1'($urandom_range(0, 1)));
        issue_request(r);
      end else begin
        z = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 20) : $urandom_range(2, 7);
        case ($urandom_range(0, 3))
          0:       s = 0;
          1:       s = $urandom_range(1, 1 << 17);
          2:       s = $urandom_range(0, (1 << SCALE_W) - 1);
          default: s = 'h10000;
        endcase
        radius = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
        nexts  = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(20, 150);
        if (nexts > TOTAL_REQUESTS - requests_sent - 1) begin
          nexts = TOTAL_REQUESTS - requests_sent - 1;
        end
        issue_request(start_req($urandom_range(0, (1 << z) - 1),
                                $urandom_range(0, (1 << z) - 1), z, s, radius));
        issue_nexts(nexts);
      end
    end
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready) begin
      if (expected_tiles.size() == 0) begin
        $error("result with no request outstanding: %h", res_o);
        errors++;
      end else begin
        want_tile = expected_tiles.pop_front();
        if (res_o.tile_x !== want_tile.tile_x) begin
          $error("tile_x: expected %0d, actual %0d", want_tile.tile_x, res_o.tile_x);
          errors++;
        end
        if (res_o.tile_y !== want_tile.tile_y) begin
          $error("tile_y: expected %0d, actual %0d", want_tile.tile_y, res_o.tile_y);
          errors++;
        end
        if (res_o.tile_zoom !== want_tile.tile_zoom) begin
          $error("tile_zoom: expected %0d, actual %0d", want_tile.tile_zoom,
                 res_o.tile_zoom);
          errors++;
        end
        if (res_o.found !== want_tile.found) begin
          $error("found: expected %0d, actual %0d", want_tile.found, res_o.found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    walk_x      = '0;
    walk_y      = '0;
    walk_zoom   = '0;
    ring_no     = '0;
    leg_q       = LEG_UP;
    leg_count   = '0;
    walk_done   = 1'b1;
    walk_scale  = '0;
    walk_radius = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_next_without_walk();
    test_low_zoom();
    test_field_extremes();
    test_full_ring_coverage();
    test_left_edge_zero_scale();
    test_center_outside_grid();
    test_random_walks();
    req_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
